@@ hdl/itaf_pkg.sv @@
// ----------------------------------------------------------------------------
// itaf_pkg - integer to ASCII formatter package
// Request and response types, conversion codes and character constants.
// ----------------------------------------------------------------------------
package itaf_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned FieldW = 7;
  localparam int unsigned CharW  = 8;
  localparam int unsigned ProdW  = 64;

  // floor(x / 10) == (x * DecRecip) >> DecShift for every 32-bit x
  localparam logic [ValueW-1:0] DecRecip = 32'hCCCC_CCCD;
  localparam int unsigned       DecShift = 35;
  localparam logic [3:0]        DecBase  = 4'd10;

  localparam logic [6:0] ChrZero   = 7'h30;
  localparam logic [6:0] ChrMinus  = 7'h2D;
  localparam logic [6:0] ChrSpace  = 7'h20;
  localparam logic [6:0] ChrLowerA = 7'h61;
  localparam logic [6:0] ChrUpperA = 7'h41;

  typedef enum logic [1:0] {
    FUNC_SDEC = 2'd0,
    FUNC_UDEC = 2'd1,
    FUNC_LHEX = 2'd2,
    FUNC_UHEX = 2'd3
  } func_e;

  typedef struct packed {
    func_e                     func;
    logic signed [ValueW-1:0]  value;
    logic [FieldW-1:0]         field_width;
    logic                      left_justify;
    logic                      zero_pad;
  } req_t;

  typedef struct packed {
    logic [CharW-1:0] char_out;
    logic             last_char;
  } rsp_t;

endpackage

@@ hdl/integer_to_ascii_formatter.sv @@
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter - printf style integer field formatter
// Turns one 32-bit value into a padded ASCII field, one character at a time.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready request channel carrying value, conversion, width and
//           the left-justify and zero-pad flags (itaf_pkg::req_t).
//   out_* : valid/ready channel, one character per transfer, last_char set on
//           the final character of the field (itaf_pkg::rsp_t).
// Timing:
//   Digits come out of one shared divide-by-base unit. Decimal takes two
//   steps a digit (reciprocal multiply into a register, then quotient and
//   remainder fix-up); hex takes one (nibble shift). Emission then moves one
//   character a cycle through the output register while out_ready_i is high,
//   plus the sign, left pad and minus steps when they have nothing to send.
//   in_ready_o is low from acceptance on and rises again once the last
//   character is loaded.
// Reset: clears the sequencer and the output register; no clearing pass.
// Stall: a character waits in the output register while out_ready_i is low;
//   the sequencer holds until it is taken. The next request can be accepted
//   while the final character of the previous field still waits.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter #(
  parameter int unsigned DIGIT_BUFFER_DEPTH = 12,
  parameter int unsigned MAX_FIELD_WIDTH    = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  itaf_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output itaf_pkg::rsp_t out_rsp_o
);

  localparam int unsigned CountW = $clog2(DIGIT_BUFFER_DEPTH + 1);
  localparam int unsigned IdxW   = $clog2(DIGIT_BUFFER_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_SIGN,
    S_PADL,
    S_MINUS,
    S_DIGITS,
    S_PADR
  } state_e;

  state_e                          state_q;
  logic [itaf_pkg::ValueW-1:0]     quot_q;
  logic [itaf_pkg::ProdW-1:0]      prod_q;
  logic [CountW-1:0]               count_q;
  logic [itaf_pkg::FieldW-1:0]     width_q;
  logic [itaf_pkg::FieldW-1:0]     pad_q;
  logic                            hex_q;
  logic                            upper_q;
  logic                            lead_q;
  logic                            inline_q;
  logic                            left_q;
  logic [6:0]                      padc_q;
  logic                            out_valid_q;
  itaf_pkg::rsp_t                  out_q;

  logic [6:0] digit_store [DIGIT_BUFFER_DEPTH];

  // ---- request decode ----
  logic                        req_neg;
  logic                        req_hex;
  logic [itaf_pkg::ValueW-1:0] req_mag;
  logic [itaf_pkg::FieldW-1:0] req_width;
  logic                        req_lead;

  always_comb begin
    req_neg   = (in_req_i.func == itaf_pkg::FUNC_SDEC) && in_req_i.value[itaf_pkg::ValueW-1];
    req_hex   = (in_req_i.func == itaf_pkg::FUNC_LHEX) ||
                (in_req_i.func == itaf_pkg::FUNC_UHEX);
    req_mag   = req_neg ? (itaf_pkg::ValueW'(0) - in_req_i.value) : in_req_i.value;
    req_width = (in_req_i.field_width > itaf_pkg::FieldW'(MAX_FIELD_WIDTH)) ?
                itaf_pkg::FieldW'(MAX_FIELD_WIDTH) : in_req_i.field_width;
    req_lead  = req_neg && (req_width != '0) && in_req_i.zero_pad;
  end

  // ---- shared divide-by-base unit ----
  logic [itaf_pkg::ValueW-1:0] q_dec;
  logic [itaf_pkg::ValueW-1:0] times10;
  logic [itaf_pkg::ValueW-1:0] rem_dec;
  logic [itaf_pkg::ValueW-1:0] q_next;
  logic [3:0]                  rem;
  logic [6:0]                  digit_chr;
  logic [6:0]                  letter;
  logic                        div_done;
  logic [7:0]                  len_fin;
  logic [7:0]                  width_ext;
  logic [itaf_pkg::FieldW-1:0] pad_fin;

  always_comb begin
    q_dec   = itaf_pkg::ValueW'(prod_q[itaf_pkg::ProdW-1:itaf_pkg::DecShift]);
    times10 = (q_dec << 3) + (q_dec << 1);
    rem_dec = quot_q - times10;
    if (hex_q) begin
      rem    = quot_q[3:0];
      q_next = quot_q >> 4;
    end else begin
      rem    = rem_dec[3:0];
      q_next = q_dec;
    end
    letter    = upper_q ? itaf_pkg::ChrUpperA : itaf_pkg::ChrLowerA;
    digit_chr = (rem < itaf_pkg::DecBase) ? (itaf_pkg::ChrZero + {3'b000, rem}) :
                (letter + {3'b000, rem} - {3'b000, itaf_pkg::DecBase});
    div_done  = (q_next == '0) || (count_q == CountW'(DIGIT_BUFFER_DEPTH - 1));
    len_fin   = 8'(count_q) + 8'd1 + 8'(inline_q);
    width_ext = {1'b0, width_q};
    pad_fin   = (width_ext > len_fin) ? itaf_pkg::FieldW'(width_ext - len_fin) : '0;
  end

  // ---- emission helpers ----
  logic            emit_ok;
  logic            emit_load;
  logic            out_load;
  logic [IdxW-1:0] rd_idx;
  logic [CountW-1:0] count_m1;
  logic            digits_last;

  assign emit_ok     = !out_valid_q || out_ready_i;
  assign count_m1    = count_q - CountW'(1);
  assign rd_idx      = count_m1[IdxW-1:0];
  assign digits_last = !(left_q && (pad_q != '0));

  // states that have a character to send this cycle
  always_comb begin
    case (state_q)
      S_SIGN:           emit_load = lead_q;
      S_PADL:           emit_load = !left_q && (pad_q != '0);
      S_MINUS:          emit_load = inline_q;
      S_DIGITS, S_PADR: emit_load = 1'b1;
      default:          emit_load = 1'b0;
    endcase
  end

  assign out_load = emit_load && emit_ok;

  // digit store: written least significant first by the divide unit
  always_ff @(posedge clk_i) begin
    if (state_q == S_DIV) begin
      digit_store[count_q[IdxW-1:0]] <= digit_chr;
    end
  end

  // ---- sequencer ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      quot_q      <= '0;
      prod_q      <= '0;
      count_q     <= '0;
      width_q     <= '0;
      pad_q       <= '0;
      hex_q       <= 1'b0;
      upper_q     <= 1'b0;
      lead_q      <= 1'b0;
      inline_q    <= 1'b0;
      left_q      <= 1'b0;
      padc_q      <= itaf_pkg::ChrSpace;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      out_valid_q <= out_load || (out_valid_q && !out_ready_i);
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            quot_q   <= req_mag;
            count_q  <= '0;
            hex_q    <= req_hex;
            upper_q  <= (in_req_i.func == itaf_pkg::FUNC_UHEX);
            lead_q   <= req_lead;
            inline_q <= req_neg && !req_lead;
            left_q   <= in_req_i.left_justify;
            padc_q   <= in_req_i.zero_pad ? itaf_pkg::ChrZero : itaf_pkg::ChrSpace;
            width_q  <= req_lead ? (req_width - itaf_pkg::FieldW'(1)) : req_width;
            state_q  <= req_hex ? S_DIV : S_MUL;
          end
        end
        S_MUL: begin
          prod_q  <= itaf_pkg::ProdW'(quot_q) * itaf_pkg::ProdW'(itaf_pkg::DecRecip);
          state_q <= S_DIV;
        end
        S_DIV: begin
          quot_q  <= q_next;
          count_q <= count_q + CountW'(1);
          if (div_done) begin
            pad_q   <= pad_fin;
            state_q <= S_SIGN;
          end else begin
            state_q <= hex_q ? S_DIV : S_MUL;
          end
        end
        S_SIGN: begin
          if (!lead_q) begin
            state_q <= S_PADL;
          end else if (emit_ok) begin
            out_q       <= '{char_out: {1'b0, itaf_pkg::ChrMinus}, last_char: 1'b0};
            state_q     <= S_PADL;
          end
        end
        S_PADL: begin
          if (left_q || (pad_q == '0)) begin
            state_q <= S_MINUS;
          end else if (emit_ok) begin
            out_q       <= '{char_out: {1'b0, padc_q}, last_char: 1'b0};
            pad_q       <= pad_q - itaf_pkg::FieldW'(1);
            if (pad_q == itaf_pkg::FieldW'(1)) begin
              state_q <= S_MINUS;
            end
          end
        end
        S_MINUS: begin
          if (!inline_q) begin
            state_q <= S_DIGITS;
          end else if (emit_ok) begin
            out_q       <= '{char_out: {1'b0, itaf_pkg::ChrMinus}, last_char: 1'b0};
            state_q     <= S_DIGITS;
          end
        end
        S_DIGITS: begin
          if (emit_ok) begin
            out_q       <= '{char_out: {1'b0, digit_store[rd_idx]},
                             last_char: (count_q == CountW'(1)) && digits_last};
            count_q     <= count_m1;
            if (count_q == CountW'(1)) begin
              state_q <= digits_last ? S_IDLE : S_PADR;
            end
          end
        end
        S_PADR: begin
          if (emit_ok) begin
            out_q       <= '{char_out: {1'b0, padc_q},
                             last_char: (pad_q == itaf_pkg::FieldW'(1))};
            pad_q       <= pad_q - itaf_pkg::FieldW'(1);
            if (pad_q == itaf_pkg::FieldW'(1)) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // ---- assertions ----
  a_accept_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_MUL || state_q == S_DIV))
    else $error("accepted request did not start digit extraction");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(DIGIT_BUFFER_DEPTH))
    else $error("digit count beyond store depth");

  a_digits_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIGITS) |-> (count_q != '0))
    else $error("digit emission with empty store");

  a_padr_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PADR) |-> (pad_q != '0) && left_q)
    else $error("right padding entered with nothing to pad");

  a_last_ends_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(state_q) != S_IDLE && state_q == S_IDLE) |-> (out_valid_q && out_q.last_char))
    else $error("field ended without last character flag");

endmodule
